### src/ost_pkg.sv
package ost_pkg;

  localparam int Capacity = 128;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int ElemW    = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  // Control that the sequencer broadcasts to every cell of the row.
  typedef struct packed {
    logic            compare;
    logic            update;
    op_e             op;
    logic            member;
    logic [CntW-1:0] count;
  } cell_ctl_t;

endpackage

### src/ordered_array_set_table.sv
// Ordered set of up to 128 distinct 32-bit values, kept in insertion order in a row of
// cells, one value per cell. An item passes through a match state, in which every cell
// compares its value against the item's element, and then an update state, in which the
// count is updated, an insert is written into the cell just past the last used one and a
// delete shifts every later cell down by one from its upper neighbor. A new item is taken
// in the update state of the previous one as long as the output register is free. Every
// item returns one result. An insert of a new value into a full set leaves the set
// unchanged and sets rejected.
module ordered_array_set_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               was_member_o,
  output logic [7:0]         count_o,
  output logic               is_empty_o,
  output logic               is_full_o,
  output logic               rejected_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MATCH  = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  localparam logic [ost_pkg::CntW-1:0] CapCnt = ost_pkg::CntW'(ost_pkg::Capacity);

  state_e                      state_q, state_d;
  ost_pkg::op_e                op_q;
  logic [ost_pkg::ElemW-1:0]   elem_q;
  logic [ost_pkg::CntW-1:0]    count_q, count_d;
  logic                        out_valid_q;
  logic                        was_member_q, rejected_q;
  logic                        out_free, in_accept, do_update;
  logic                        member, reject;
  ost_pkg::cell_ctl_t          ctl;

  logic [ost_pkg::ElemW-1:0]   cell_val [ost_pkg::Capacity];
  logic [ost_pkg::Capacity:0]  hit_chain;
  logic [ost_pkg::Capacity-1:0] match_vec;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) || ((state_q == S_UPDATE) && out_free));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign do_update  = (state_q == S_UPDATE) && out_free;

  assign member = (op_q != ost_pkg::OP_CLEAR) && (|match_vec);
  assign reject = (op_q == ost_pkg::OP_INSERT) && !member && (count_q == CapCnt);

  always_comb begin
    count_d = count_q;
    case (op_q)
      ost_pkg::OP_CLEAR:  count_d = '0;
      ost_pkg::OP_INSERT: if (!member && (count_q != CapCnt)) count_d = count_q + 1'b1;
      ost_pkg::OP_DELETE: if (member) count_d = count_q - 1'b1;
      default:            count_d = count_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_MATCH;
      S_MATCH:  state_d = S_UPDATE;
      S_UPDATE: if (out_free) state_d = in_valid_i ? S_MATCH : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign ctl.compare = (state_q == S_MATCH);
  assign ctl.update  = do_update;
  assign ctl.op      = op_q;
  assign ctl.member  = member;
  assign ctl.count   = count_q;

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < ost_pkg::Capacity; i++) begin : g_cell
    logic [ost_pkg::ElemW-1:0] next_val;
    if (i == ost_pkg::Capacity - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end
    ost_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .elem_i     (elem_q),
      .idx_i      (ost_pkg::IdxW'(i)),
      .next_val_i (next_val),
      .hit_i      (hit_chain[i]),
      .val_o      (cell_val[i]),
      .hit_o      (hit_chain[i+1]),
      .match_o    (match_vec[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_update) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= ost_pkg::op_e'(op_i);
      elem_q <= element_i;
    end
    if (do_update) begin
      was_member_q <= member;
      rejected_q   <= reject;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign was_member_o = was_member_q;
  assign count_o      = count_q;
  assign is_empty_o   = (count_q == '0);
  assign is_full_o    = (count_q == CapCnt);
  assign rejected_o   = rejected_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("count exceeds capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) && (count_q != '0) |->
      (count_q == $past(count_q) + 1'b1) || (count_q + 1'b1 == $past(count_q)))
    else $error("count moved by more than one");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_UPDATE))
    else $error("result appeared outside the update cycle");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> is_full_o && !was_member_o)
    else $error("rejected insert while not full");

endmodule

### src/ost_cell.sv
module ost_cell (
  input  logic                      clk_i,
  input  ost_pkg::cell_ctl_t        ctl_i,
  input  logic [ost_pkg::ElemW-1:0] elem_i,
  input  logic [ost_pkg::IdxW-1:0]  idx_i,
  input  logic [ost_pkg::ElemW-1:0] next_val_i,
  input  logic                      hit_i,
  output logic [ost_pkg::ElemW-1:0] val_o,
  output logic                      hit_o,
  output logic                      match_o
);

  logic [ost_pkg::ElemW-1:0] val_q;
  logic                      match_q;
  logic                      in_use;
  logic                      tail;

  assign in_use  = {1'b0, idx_i} < ctl_i.count;
  assign tail    = {1'b0, idx_i} == ctl_i.count;
  // Once a match is seen at or below this cell, a delete makes the cell take its upper neighbor's value.
  assign hit_o   = hit_i | match_q;
  assign val_o   = val_q;
  assign match_o = match_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.compare) begin
      match_q <= (val_q == elem_i) && in_use;
    end
    if (ctl_i.update) begin
      case (ctl_i.op)
        ost_pkg::OP_INSERT: begin
          if (!ctl_i.member && tail) begin
            val_q <= elem_i;
          end
        end
        ost_pkg::OP_DELETE: begin
          if (hit_o) begin
            val_q <= next_val_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
